/* src/dpihb_pkg.sv */
// shared types and constants for the dual pi h-bridge drive
package dpihb_pkg;

   // fixed field widths
   localparam int DATA_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int AMP_W   = 13;
   localparam int ERR_W   = 17;
   localparam int DRIVE_W = 14;
   localparam int CMP_W   = 13;
   localparam int FRAC_W  = 8;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_KP_LEFT   = 5'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KI_LEFT   = 5'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_KP_RIGHT  = 5'd8;
   localparam logic [CSR_ADDR_W-1:0] CSR_KI_RIGHT  = 5'd12;
   localparam logic [CSR_ADDR_W-1:0] CSR_AMPLITUDE = 5'd16;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;
   localparam logic [AMP_W-1:0]  AMP_RESET  = 13'd7200;

   // result transaction, last field in the lowest bits
   typedef struct packed {
      logic [CMP_W-1:0]          right_high_compare;
      logic [CMP_W-1:0]          right_low_compare;
      logic [CMP_W-1:0]          left_high_compare;
      logic [CMP_W-1:0]          left_low_compare;
      logic signed [DRIVE_W-1:0] drive_right;
      logic signed [DRIVE_W-1:0] drive_left;
   } rsp_type;

endpackage

/* src/dpihb_lane.sv */
// one motor lane: error, incremental pi update, saturated accumulator
module dpihb_lane #(
   parameter int FULL_SCALE = 7200,
   parameter int ACC_W      = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic signed [dpihb_pkg::DATA_W-1:0]   target,
   input  logic signed [dpihb_pkg::DATA_W-1:0]   count,
   input  logic [dpihb_pkg::GAIN_W-1:0]          kp,
   input  logic [dpihb_pkg::GAIN_W-1:0]          ki,
   output logic signed [ACC_W-1:0]               accum
);

   localparam int ERR_W  = dpihb_pkg::ERR_W;
   localparam int FRAC_W = dpihb_pkg::FRAC_W;
   localparam int PP_W   = dpihb_pkg::GAIN_W + 1 + ERR_W + 1;
   localparam int IP_W   = dpihb_pkg::GAIN_W + 1 + ERR_W;
   localparam int SUM_W  = (ACC_W + FRAC_W > PP_W ? ACC_W + FRAC_W : PP_W) + 2;
   localparam logic signed [SUM_W-1:0] FS_POS = SUM_W'(FULL_SCALE);
   localparam logic signed [SUM_W-1:0] FS_NEG = -FS_POS;

   logic signed [ACC_W-1:0] accum_ff, accum_in;
   logic signed [ERR_W-1:0] prev_ff, prev_in;
   logic signed [ERR_W-1:0] err;
   logic signed [ERR_W:0]   diff;
   logic signed [PP_W-1:0]  p_prod;
   logic signed [IP_W-1:0]  i_prod;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] quo;
   logic                    round_up;

   // error and its change since the last tick
   assign err  = $signed({target[dpihb_pkg::DATA_W-1], target})
               - $signed({count[dpihb_pkg::DATA_W-1], count});
   assign diff = $signed({err[ERR_W-1], err}) - $signed({prev_ff[ERR_W-1], prev_ff});

   // gain products, gains are unsigned q8.8
   assign p_prod = $signed({1'b0, kp}) * diff;
   assign i_prod = $signed({1'b0, ki}) * err;

   // scaled accumulator plus increment
   assign sum = $signed({{(SUM_W-ACC_W-FRAC_W){accum_ff[ACC_W-1]}}, accum_ff, {FRAC_W{1'b0}}})
              + SUM_W'(p_prod) + SUM_W'(i_prod);

   // drop the fraction, truncating toward zero
   assign round_up = sum[SUM_W-1] && (|sum[FRAC_W-1:0]);
   assign quo      = (sum >>> FRAC_W) + $signed({{(SUM_W-1){1'b0}}, round_up});

   // saturate at full scale
   always_comb begin
      if (quo > FS_POS) begin
         accum_in = FS_POS[ACC_W-1:0];
      end else if (quo < FS_NEG) begin
         accum_in = FS_NEG[ACC_W-1:0];
      end else begin
         accum_in = quo[ACC_W-1:0];
      end
      prev_in = err;
   end

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         prev_ff  <= '0;
      end else if (load) begin
         accum_ff <= accum_in;
         prev_ff  <= prev_in;
      end
   end

   assign accum = accum_ff;

endmodule

/* src/dpihb_merge.sv */
// merging stage: amplitude clamp and h-bridge compares for both lanes
module dpihb_merge #(
   parameter int FULL_SCALE = 7200,
   parameter int ACC_W      = 14
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic [dpihb_pkg::AMP_W-1:0]         amplitude,
   input  logic signed [ACC_W-1:0]             accum_left,
   input  logic signed [ACC_W-1:0]             accum_right,
   output dpihb_pkg::rsp_type                  rsp
);

   localparam int CLP_W = (ACC_W > dpihb_pkg::DRIVE_W ? ACC_W : dpihb_pkg::DRIVE_W) + 1;
   localparam int BR_W  = CLP_W + 1;
   localparam logic signed [BR_W-1:0] FS_BR = BR_W'(FULL_SCALE);

   dpihb_pkg::rsp_type rsp_ff, rsp_in;

   // clamp one accumulator to +-amplitude
   function automatic logic signed [dpihb_pkg::DRIVE_W-1:0] clamp_amp(
      input logic signed [ACC_W-1:0]      acc,
      input logic [dpihb_pkg::AMP_W-1:0]  amp
   );
      logic signed [CLP_W-1:0] a_pos;
      logic signed [CLP_W-1:0] a_neg;
      logic signed [CLP_W-1:0] v;
      a_pos = $signed({{(CLP_W-dpihb_pkg::AMP_W){1'b0}}, amp});
      a_neg = -a_pos;
      v     = CLP_W'(acc);
      if (v < a_neg) begin
         v = a_neg;
      end
      if (v > a_pos) begin
         v = a_pos;
      end
      return v[dpihb_pkg::DRIVE_W-1:0];
   endfunction

   // low side compare of the bridge pair
   function automatic logic [dpihb_pkg::CMP_W-1:0] low_cmp(
      input logic signed [dpihb_pkg::DRIVE_W-1:0] drive
   );
      logic [dpihb_pkg::CMP_W-1:0] r;
      if (drive[dpihb_pkg::DRIVE_W-1]) begin
         r = FS_BR[dpihb_pkg::CMP_W-1:0];
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // high side compare of the bridge pair
   function automatic logic [dpihb_pkg::CMP_W-1:0] high_cmp(
      input logic signed [dpihb_pkg::DRIVE_W-1:0] drive
   );
      logic signed [BR_W-1:0] s;
      if (drive[dpihb_pkg::DRIVE_W-1]) begin
         s = FS_BR + BR_W'(drive);
      end else begin
         s = BR_W'(drive);
      end
      return s[dpihb_pkg::CMP_W-1:0];
   endfunction

   // combine both lanes into one result
   always_comb begin
      rsp_in.drive_left         = clamp_amp(accum_left, amplitude);
      rsp_in.drive_right        = clamp_amp(accum_right, amplitude);
      rsp_in.left_low_compare   = low_cmp(rsp_in.drive_left);
      rsp_in.left_high_compare  = high_cmp(rsp_in.drive_left);
      rsp_in.right_low_compare  = low_cmp(rsp_in.drive_right);
      rsp_in.right_high_compare = high_cmp(rsp_in.drive_right);
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* src/dual_incremental_pi_hbridge_drive.sv */
// Dual incremental PI wheel drive with H-bridge compare outputs. Each request
// transaction is one control tick for both motors; the two motor lanes run in
// parallel and a merging stage clamps the drives to the amplitude register and
// forms the bridge compare pairs. One transaction is taken every clock cycle
// while the output is not stalled; lane state is updated on accept and the
// merging stage then registers the result. A result held by the consumer
// stalls new requests. The rate is set by the accumulator loop in each lane,
// a combinational multiply-add with saturation that must close before the
// next tick's update. Gains and the amplitude must be written through the csr
// port by the user while no tick is in flight; the block does not enforce it.
module dual_incremental_pi_hbridge_drive #(
   parameter int FULL_SCALE = 7200
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // target_left, count_left, target_right, count_right
   input  logic [63:0]                           req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // drive_left, drive_right, left_low_compare, left_high_compare,
   // right_low_compare, right_high_compare
   output logic [79:0]                           rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [dpihb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dpihb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dpihb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   localparam int ACC_W = $clog2(FULL_SCALE + 1) + 1;
   localparam int DW    = dpihb_pkg::DATA_W;

   logic [dpihb_pkg::GAIN_W-1:0] kp_left_ff, ki_left_ff, kp_right_ff, ki_right_ff;
   logic [dpihb_pkg::AMP_W-1:0]  amplitude_ff;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         advance, accept, csr_write;
   logic signed [ACC_W-1:0]      accum_left, accum_right;
   dpihb_pkg::rsp_type           rsp;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_left_ff   <= dpihb_pkg::GAIN_RESET;
         ki_left_ff   <= dpihb_pkg::GAIN_RESET;
         kp_right_ff  <= dpihb_pkg::GAIN_RESET;
         ki_right_ff  <= dpihb_pkg::GAIN_RESET;
         amplitude_ff <= dpihb_pkg::AMP_RESET;
      end else if (csr_write) begin
         case (csr_paddr)
            dpihb_pkg::CSR_KP_LEFT:   kp_left_ff   <= csr_pwdata[dpihb_pkg::GAIN_W-1:0];
            dpihb_pkg::CSR_KI_LEFT:   ki_left_ff   <= csr_pwdata[dpihb_pkg::GAIN_W-1:0];
            dpihb_pkg::CSR_KP_RIGHT:  kp_right_ff  <= csr_pwdata[dpihb_pkg::GAIN_W-1:0];
            dpihb_pkg::CSR_KI_RIGHT:  ki_right_ff  <= csr_pwdata[dpihb_pkg::GAIN_W-1:0];
            dpihb_pkg::CSR_AMPLITUDE: amplitude_ff <= csr_pwdata[dpihb_pkg::AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr)
         dpihb_pkg::CSR_KP_LEFT:   csr_prdata = dpihb_pkg::CSR_DATA_W'(kp_left_ff);
         dpihb_pkg::CSR_KI_LEFT:   csr_prdata = dpihb_pkg::CSR_DATA_W'(ki_left_ff);
         dpihb_pkg::CSR_KP_RIGHT:  csr_prdata = dpihb_pkg::CSR_DATA_W'(kp_right_ff);
         dpihb_pkg::CSR_KI_RIGHT:  csr_prdata = dpihb_pkg::CSR_DATA_W'(ki_right_ff);
         dpihb_pkg::CSR_AMPLITUDE: csr_prdata = dpihb_pkg::CSR_DATA_W'(amplitude_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline control: lane stage then output register
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         s1_valid_in  = accept;
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // motor lanes
   dpihb_lane #(.FULL_SCALE(FULL_SCALE), .ACC_W(ACC_W)) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .target ($signed(req_tdata[DW-1:0])),
      .count  ($signed(req_tdata[2*DW-1:DW])),
      .kp     (kp_left_ff),
      .ki     (ki_left_ff),
      .accum  (accum_left)
   );

   dpihb_lane #(.FULL_SCALE(FULL_SCALE), .ACC_W(ACC_W)) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .target ($signed(req_tdata[3*DW-1:2*DW])),
      .count  ($signed(req_tdata[4*DW-1:3*DW])),
      .kp     (kp_right_ff),
      .ki     (ki_right_ff),
      .accum  (accum_right)
   );

   // clamp and bridge mapping
   dpihb_merge #(.FULL_SCALE(FULL_SCALE), .ACC_W(ACC_W)) u_merge (
      .clock       (clock),
      .load        (advance && s1_valid_ff),
      .amplitude   (amplitude_ff),
      .accum_left  (accum_left),
      .accum_right (accum_right),
      .rsp         (rsp)
   );

   assign rsp_tdata  = rsp;
   assign rsp_tvalid = out_valid_ff;

`ifndef ASSERT_OFF
   // an accepted tick always occupies the lane stage next cycle
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted transaction did not reach the lane stage");

   // accumulators stay within full scale
   a_accum_range: assert property (@(posedge clock) disable iff (reset)
      ($signed(accum_left) <= FULL_SCALE) && ($signed(accum_left) >= -FULL_SCALE)
      && ($signed(accum_right) <= FULL_SCALE) && ($signed(accum_right) >= -FULL_SCALE))
      else $error("accumulator beyond full scale");

   // forward drive keeps the low side compare at zero
   a_bridge_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.drive_left[dpihb_pkg::DRIVE_W-1]) |-> (rsp.left_low_compare == '0))
      else $error("bridge compare pair inconsistent with drive sign");
`endif

endmodule
